FILE: sv/hpps_pkg.sv
`default_nettype none

package hpps_pkg;

    // Field widths
    localparam int unsigned DIST_W   = 9;
    localparam int unsigned ADV_W    = 8;
    localparam int unsigned PULSE_W  = 10;
    localparam int unsigned WIN_W    = 12;
    localparam int unsigned TIME_W   = 13;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 8;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_PULSE = 3'd0,
        REG_LONG_PULSE  = 3'd1,
        REG_GAP         = 3'd2,
        REG_WINDOW      = 3'd3,
        REG_NEAR        = 3'd4,
        REG_MID         = 3'd5,
        REG_FAR         = 3'd6,
        REG_NO_ECHO     = 3'd7
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic [PULSE_W-1:0] SHORT_PULSE_RST = 10'd100;
    localparam logic [PULSE_W-1:0] LONG_PULSE_RST  = 10'd200;
    localparam logic [PULSE_W-1:0] GAP_RST         = 10'd150;
    localparam logic [WIN_W-1:0]   WINDOW_RST      = 12'd2000;
    localparam logic [DIST_W-1:0]  NEAR_RST        = 9'd80;
    localparam logic [DIST_W-1:0]  MID_RST         = 9'd120;
    localparam logic [DIST_W-1:0]  FAR_RST         = 9'd180;
    localparam logic [DIST_W-1:0]  NO_ECHO_RST     = 9'd400;

    typedef enum logic [1:0] {
        SEC_LEFT        = 2'd0,
        SEC_LEFT_FRONT  = 2'd1,
        SEC_RIGHT_FRONT = 2'd2,
        SEC_RIGHT       = 2'd3
    } sector_t;

    typedef enum logic [1:0] {
        BAND_NEAR  = 2'd0,
        BAND_MID   = 2'd1,
        BAND_FAR   = 2'd2,
        BAND_CLEAR = 2'd3
    } band_t;

    typedef struct packed {
        sector_t sector;
        band_t   band;
    } pattern_t;

    localparam pattern_t PATTERN_RST   = '{sector: SEC_LEFT,  band: BAND_NEAR};
    localparam pattern_t PATTERN_CLEAR = '{sector: SEC_RIGHT, band: BAND_CLEAR};

    // Number of pulses in a pattern
    function automatic logic [IDX_W-1:0] pat_len(input pattern_t p);
        logic [IDX_W-1:0] n;
        case (p.band)
            BAND_NEAR:  n = 3'd2;
            BAND_MID:   n = 3'd3;
            BAND_FAR:   n = 3'd4;
            default:    n = (p.sector == SEC_RIGHT) ? 3'd1 : 3'd0;
        endcase
        return n;
    endfunction

    // Bit k set: slot k is a long pulse
    function automatic logic [3:0] pat_bits(input pattern_t p);
        logic [3:0] b;
        case ({p.sector, p.band})
            4'd0:    b = 4'h3;
            4'd1:    b = 4'h3;
            4'd2:    b = 4'h7;
            4'd4:    b = 4'h1;
            4'd5:    b = 4'h1;
            4'd6:    b = 4'h3;
            4'd8:    b = 4'h2;
            4'd9:    b = 4'h4;
            4'd10:   b = 4'hC;
            4'd12:   b = 4'h0;
            4'd13:   b = 4'h6;
            4'd14:   b = 4'hE;
            default: b = 4'h0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: sv/haptic_proximity_pattern_sequencer_core.sv
// Haptic proximity pattern sequencer.
// Input stream (s_*): one request per sensor loop with three distances in cm
// (0 = no echo) and the milliseconds elapsed since the previous request.
// Output stream (m_*): exactly one result per input request, in order:
// pulse start and length, a new-class flag, and the sector and band of the
// pattern now playing.
// Configuration (cfg_*): index and data write channel, always ready; write
// only while the block is idle. Register indexes follow hpps_pkg::cfg_reg_t.
// A request accepted at one edge is captured in the input register,
// evaluated and loaded into the result register at the next edge the result
// register is free.
// One request per cycle while m_tready stays high; all timing, pulse and
// class logic sits between the input register and the result register and
// updates the sequencer state as the request moves across.
// A stalled receiver holds the result register; the input register still
// takes one more request, then s_tready drops until m_tready returns.
// Reset (aresetn low, synchronous): both registers empty, timers and pulse
// index cleared, pattern left/near, configuration back to default values.
`default_nettype none

module haptic_proximity_pattern_sequencer_core
    import hpps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata: left_cm[8:0], front_cm[17:9], right_cm[26:18], advance_ms[34:27], zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tdata: pulse_start[0], pulse_long[1], class_valid[2], sector[4:3], band[6:5], zero pad
    output logic [M_TDATA_W-1:0]       m_tdata,
    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [PULSE_W-1:0] short_pulse_reg, long_pulse_reg, gap_reg;
    logic [WIN_W-1:0]   window_reg;
    logic [DIST_W-1:0]  near_reg, mid_reg, far_reg, no_echo_reg;

    // Input register
    logic               in_valid_reg;
    logic [DIST_W-1:0]  in_left_reg, in_front_reg, in_right_reg;
    logic [ADV_W-1:0]   in_adv_reg;

    // Sequencer state
    logic [IDX_W-1:0]   pulse_idx_reg, pulse_idx_next;
    logic [TIME_W-1:0]  next_due_reg, next_due_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    pattern_t           pattern_reg, pattern_next;

    // Result register
    logic               out_valid_reg;
    logic               out_start_reg, out_start_next;
    logic               out_long_reg, out_long_next;
    logic               out_class_reg, out_class_next;
    pattern_t           out_pat_reg;

    logic               step;

    assign cfg_ready = 1'b1;
    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_pat_reg.band, out_pat_reg.sector,
                        out_class_reg, out_long_reg, out_start_reg};

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_pulse_reg <= SHORT_PULSE_RST;
            long_pulse_reg  <= LONG_PULSE_RST;
            gap_reg         <= GAP_RST;
            window_reg      <= WINDOW_RST;
            near_reg        <= NEAR_RST;
            mid_reg         <= MID_RST;
            far_reg         <= FAR_RST;
            no_echo_reg     <= NO_ECHO_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_SHORT_PULSE: short_pulse_reg <= cfg_data[PULSE_W-1:0];
                REG_LONG_PULSE:  long_pulse_reg  <= cfg_data[PULSE_W-1:0];
                REG_GAP:         gap_reg         <= cfg_data[PULSE_W-1:0];
                REG_WINDOW:      window_reg      <= cfg_data[WIN_W-1:0];
                REG_NEAR:        near_reg        <= cfg_data[DIST_W-1:0];
                REG_MID:         mid_reg         <= cfg_data[DIST_W-1:0];
                REG_FAR:         far_reg         <= cfg_data[DIST_W-1:0];
                REG_NO_ECHO:     no_echo_reg     <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_left_reg  <= s_tdata[8:0];
            in_front_reg <= s_tdata[17:9];
            in_right_reg <= s_tdata[26:18];
            in_adv_reg   <= s_tdata[34:27];
        end
    end

    // Window timer, saturating
    logic [TIME_W:0]   elapsed_sum;
    logic [TIME_W-1:0] elapsed_upd;

    always_comb begin
        elapsed_sum = {1'b0, elapsed_reg} + (TIME_W+1)'(in_adv_reg);
        elapsed_upd = elapsed_sum[TIME_W] ? TIME_MAX : elapsed_sum[TIME_W-1:0];
    end

    // Pulse slot logic
    logic [IDX_W-1:0]   cur_len;
    logic [3:0]         cur_bits;
    logic               slot_due, slot_long;
    logic [PULSE_W:0]   step_ms;
    logic [TIME_W:0]    due_sum;
    logic [TIME_W-1:0]  due_upd;

    always_comb begin
        cur_len   = pat_len(pattern_reg);
        cur_bits  = pat_bits(pattern_reg);
        slot_long = cur_bits[pulse_idx_reg[1:0]];
        slot_due  = !pulse_idx_reg[2] &&
                    ((pulse_idx_reg == '0) || (elapsed_upd >= next_due_reg));
        step_ms   = (slot_long ? {1'b0, long_pulse_reg} : {1'b0, short_pulse_reg})
                    + {1'b0, gap_reg};
        due_sum   = {1'b0, next_due_reg} + (TIME_W+1)'(step_ms);
        due_upd   = due_sum[TIME_W] ? TIME_MAX : due_sum[TIME_W-1:0];
    end

    // Classification of the nearest sector
    logic [DIST_W-1:0] l_eff, f_eff, r_eff;
    logic [DIST_W:0]   lf_sum, rf_sum;
    logic [DIST_W-1:0] cand1, cand2, low0, low1, low2, low3;
    logic              hit0, hit1, hit2, hit3;
    sector_t           near_sec;
    pattern_t          new_pat;

    always_comb begin
        l_eff  = (in_left_reg  == '0) ? no_echo_reg : in_left_reg;
        f_eff  = (in_front_reg == '0) ? no_echo_reg : in_front_reg;
        r_eff  = (in_right_reg == '0) ? no_echo_reg : in_right_reg;
        lf_sum = {1'b0, l_eff} + {1'b0, f_eff};
        rf_sum = {1'b0, r_eff} + {1'b0, f_eff};
        cand1  = lf_sum[DIST_W:1];
        cand2  = rf_sum[DIST_W:1];
        // strict compares: first of equals keeps the win
        hit0 = l_eff < no_echo_reg;
        low0 = hit0 ? l_eff : no_echo_reg;
        hit1 = cand1 < low0;
        low1 = hit1 ? cand1 : low0;
        hit2 = cand2 < low1;
        low2 = hit2 ? cand2 : low1;
        hit3 = r_eff < low2;
        low3 = hit3 ? r_eff : low2;
        if (hit3) begin
            near_sec = SEC_RIGHT;
        end else if (hit2) begin
            near_sec = SEC_RIGHT_FRONT;
        end else if (hit1) begin
            near_sec = SEC_LEFT_FRONT;
        end else begin
            near_sec = SEC_LEFT;
        end
        if (!(hit0 || hit1 || hit2 || hit3)) begin
            new_pat = PATTERN_CLEAR;
        end else if (low3 < near_reg) begin
            new_pat = '{sector: near_sec, band: BAND_NEAR};
        end else if (low3 < mid_reg) begin
            new_pat = '{sector: near_sec, band: BAND_MID};
        end else if (low3 < far_reg) begin
            new_pat = '{sector: near_sec, band: BAND_FAR};
        end else begin
            new_pat = PATTERN_CLEAR;
        end
    end

    // Next state and result for the request in the input register
    always_comb begin
        pulse_idx_next = pulse_idx_reg;
        next_due_next  = next_due_reg;
        elapsed_next   = elapsed_upd;
        pattern_next   = pattern_reg;
        out_start_next = 1'b0;
        out_long_next  = 1'b0;
        out_class_next = 1'b0;
        if (slot_due) begin
            if (pulse_idx_reg < cur_len) begin
                out_start_next = 1'b1;
                out_long_next  = slot_long;
                next_due_next  = due_upd;
                pulse_idx_next = pulse_idx_reg + 3'd1;
            end else if (pulse_idx_reg >= 3'd2) begin
                // remaining slots are empty
                pulse_idx_next = 3'd4;
            end
        end
        if (elapsed_upd >= TIME_W'(window_reg)) begin
            pulse_idx_next = '0;
            next_due_next  = '0;
            elapsed_next   = '0;
            pattern_next   = new_pat;
            out_class_next = 1'b1;
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_idx_reg <= '0;
            next_due_reg  <= '0;
            elapsed_reg   <= '0;
            pattern_reg   <= PATTERN_RST;
        end else if (step) begin
            pulse_idx_reg <= pulse_idx_next;
            next_due_reg  <= next_due_next;
            elapsed_reg   <= elapsed_next;
            pattern_reg   <= pattern_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_start_reg <= out_start_next;
            out_long_reg  <= out_long_next;
            out_class_reg <= out_class_next;
            out_pat_reg   <= pattern_next;
        end
    end

endmodule

`default_nettype wire
